// ----- sv/m3h_pkg.sv -----
// ----------------------------------------------------------------------------
// m3h_pkg: shared definitions for the bit-length MurmurHash3 x64 hash unit.
// Holds the hash constants, the sequencer state type and the request and
// response bundles of the shared 64-bit multiplier.
// ----------------------------------------------------------------------------
`default_nettype none

package m3h_pkg;

	// Word widths of the datapath.
	localparam int unsigned WORD_W = 64;
	localparam int unsigned HALF_W = 32;
	localparam int unsigned TOT_W  = 32;

	// Block scramble multipliers and lane offsets.
	localparam logic [WORD_W-1:0] MUL_A   = 64'h87c37b91114253d5;
	localparam logic [WORD_W-1:0] MUL_B   = 64'h4cf5ad432745937f;
	localparam logic [WORD_W-1:0] ADD_ONE = 64'h0000000052dce729;
	localparam logic [WORD_W-1:0] ADD_TWO = 64'h0000000038495ab5;

	// Finalization multipliers.
	localparam logic [WORD_W-1:0] FIN_A = 64'hff51afd7ed558ccd;
	localparam logic [WORD_W-1:0] FIN_B = 64'hc4ceb9fe1a85ec53;

	// Sequencer states of the hash unit.
	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SA1,
		ST_SA2,
		ST_SB1,
		ST_SB2,
		ST_L1_X5,
		ST_L1_ADD,
		ST_L2_X5,
		ST_L2_ADD,
		ST_FIN_XOR,
		ST_FIN_ADD1,
		ST_FIN_ADD2,
		ST_FM_A,
		ST_FM_B,
		ST_SUM
	} m3h_state_t;

	// Request to the shared multiplier: operands are taken on start.
	typedef struct packed {
		logic              start;
		logic [WORD_W-1:0] a;
		logic [WORD_W-1:0] b;
	} m3h_mul_req_t;

	// Response of the shared multiplier: product is valid while done is high.
	typedef struct packed {
		logic              busy;
		logic              done;
		logic [WORD_W-1:0] product;
	} m3h_mul_rsp_t;

endpackage

`default_nettype wire

// ----- sv/m3h_if.sv -----
// ----------------------------------------------------------------------------
// m3h_if: valid/ready channels of the hash unit.
// m3h_msg_if carries one message block, m3h_hash_if carries one hash.
// ----------------------------------------------------------------------------
`default_nettype none

interface m3h_msg_if;
	logic        valid;
	logic        ready;
	logic [63:0] word_low;
	logic [63:0] word_high;
	logic [4:0]  valid_bytes;
	logic [7:0]  partial_byte;
	logic [2:0]  partial_bits;
	logic        last;

	modport source (
		output valid, word_low, word_high, valid_bytes, partial_byte, partial_bits, last,
		input  ready
	);

	modport sink (
		input  valid, word_low, word_high, valid_bytes, partial_byte, partial_bits, last,
		output ready
	);
endinterface

interface m3h_hash_if;
	logic        valid;
	logic        ready;
	logic [63:0] hash_value;

	modport source (
		output valid, hash_value,
		input  ready
	);

	modport sink (
		input  valid, hash_value,
		output ready
	);
endinterface

`default_nettype wire

// ----- sv/murmur3_x64_bit_length_hash_unit.sv -----
// ----------------------------------------------------------------------------
// murmur3_x64_bit_length_hash_unit: streaming 64-bit MurmurHash3 x64 hash of
// a message given in 16-byte blocks, with a final tail and partial byte.
// ----------------------------------------------------------------------------
//
//  Channel    Direction  Contents
//  msg_in     input      word_low, word_high, valid_bytes, partial_byte,
//                        partial_bits, last
//  hash_out   output     hash_value, one per message
//  seed_wr    config     seed_wr_en, seed_wr_data
//
//  Every 64-bit multiply runs on one shared multiplier, so a non-last block
//  runs four multiplies plus four add steps from one accepted transaction
//  to the next. The last block runs block or tail mixing, the partial byte,
//  finalization with two fmix passes and the lane sum.
//  arst_n clears the sequencer, seed and byte total; no clearing pass.
//  msg_in.ready is low while a block is being mixed; a hash waiting on a
//  stalled hash_out holds only the next message's final sum step.
// ----------------------------------------------------------------------------
`default_nettype none

module murmur3_x64_bit_length_hash_unit (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        seed_wr_en,
	input  wire logic [63:0] seed_wr_data,
	m3h_msg_if.sink          msg_in,
	m3h_hash_if.source       hash_out
);

	m3h_pkg::m3h_state_t state_q;
	m3h_pkg::m3h_state_t state_d;

	m3h_pkg::m3h_mul_req_t mul_req;
	m3h_pkg::m3h_mul_rsp_t mul_rsp;

	logic [63:0] seed_q;
	logic [63:0] lane1_q;
	logic [63:0] lane2_q;
	logic [63:0] k_q;
	logic [63:0] lo_q;
	logic [63:0] hi_q;
	logic [63:0] hash_q;
	logic [31:0] tot_q;
	logic [7:0]  part_q;
	logic        full_q;
	logic        one_q;
	logic        pend_q;
	logic        last_q;
	logic        in_msg_q;
	logic        fm_q;
	logic        go_q;
	logic        out_valid_q;

	logic        accept;
	logic [4:0]  nb_sat;
	logic        is_full;
	logic        one_in;
	logic        two_in;
	logic        part_in;
	logic [3:0]  lo_n;
	logic [3:0]  hi_n;
	logic [7:0]  part_val;
	logic [31:0] tot_inc;
	logic        mul_state;
	logic [63:0] fm_x;
	logic [63:0] l1_mix;
	logic [63:0] l2_mix;
	logic [63:0] fm_out;

	// Mask that keeps the low n bytes of a word; eight or more keeps all.
	function automatic logic [63:0] byte_mask(input logic [3:0] n);
		logic [63:0] m;
		for (int i = 0; i < 8; i++) begin
			m[8*i +: 8] = (4'(i) < n) ? 8'hff : 8'h00;
		end
		return m;
	endfunction

	m3h_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (mul_req),
		.rsp    (mul_rsp)
	);

	// Decode of the incoming block: which mixing passes it needs.
	assign accept   = msg_in.valid && msg_in.ready;
	assign nb_sat   = (msg_in.valid_bytes > 5'd16) ? 5'd16 : msg_in.valid_bytes;
	assign is_full  = !msg_in.last || (nb_sat == 5'd16);
	assign two_in   = !is_full && (nb_sat > 5'd8);
	assign one_in   = !is_full && (nb_sat != 5'd0);
	assign part_in  = msg_in.last && (msg_in.partial_bits != 3'd0);
	assign lo_n     = (nb_sat >= 5'd8) ? 4'd8 : nb_sat[3:0];
	assign hi_n     = (nb_sat > 5'd8) ? 4'(nb_sat - 5'd8) : 4'd0;
	assign part_val = msg_in.partial_byte >> (4'd8 - {1'b0, msg_in.partial_bits});
	assign tot_inc  = msg_in.last ? {27'b0, nb_sat} : 32'd16;

	// Lane updates that follow a scramble or a finalization multiply.
	assign l1_mix = lane1_q ^ mul_rsp.product;
	assign l2_mix = lane2_q ^ mul_rsp.product;
	assign fm_out = mul_rsp.product ^ (mul_rsp.product >> 33);
	assign fm_x   = fm_q ? lane2_q : lane1_q;

	assign mul_state = (state_q == m3h_pkg::ST_SA1) || (state_q == m3h_pkg::ST_SA2) ||
		(state_q == m3h_pkg::ST_SB1) || (state_q == m3h_pkg::ST_SB2) ||
		(state_q == m3h_pkg::ST_FM_A) || (state_q == m3h_pkg::ST_FM_B);

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= m3h_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and multiplier operands.
	always_comb begin
		state_d       = state_q;
		mul_req.start = mul_state && !go_q;
		mul_req.a     = '0;
		mul_req.b     = '0;
		case (state_q)
			m3h_pkg::ST_IDLE: begin
				if (accept) begin
					if (is_full) begin
						state_d = m3h_pkg::ST_SA1;
					end else if (two_in) begin
						state_d = m3h_pkg::ST_SB1;
					end else if (one_in || part_in) begin
						state_d = m3h_pkg::ST_SA1;
					end else begin
						state_d = m3h_pkg::ST_FIN_XOR;
					end
				end
			end
			m3h_pkg::ST_SA1: begin
				mul_req.a = (full_q || one_q) ? lo_q : {56'b0, part_q};
				mul_req.b = m3h_pkg::MUL_A;
				if (mul_rsp.done) begin
					state_d = m3h_pkg::ST_SA2;
				end
			end
			m3h_pkg::ST_SA2: begin
				mul_req.a = {k_q[32:0], k_q[63:33]};
				mul_req.b = m3h_pkg::MUL_B;
				if (mul_rsp.done) begin
					if (full_q) begin
						state_d = m3h_pkg::ST_L1_X5;
					end else if (one_q && pend_q) begin
						state_d = m3h_pkg::ST_SA1;
					end else begin
						state_d = m3h_pkg::ST_FIN_XOR;
					end
				end
			end
			m3h_pkg::ST_L1_X5: begin
				state_d = m3h_pkg::ST_L1_ADD;
			end
			m3h_pkg::ST_L1_ADD: begin
				state_d = m3h_pkg::ST_SB1;
			end
			m3h_pkg::ST_SB1: begin
				mul_req.a = hi_q;
				mul_req.b = m3h_pkg::MUL_B;
				if (mul_rsp.done) begin
					state_d = m3h_pkg::ST_SB2;
				end
			end
			m3h_pkg::ST_SB2: begin
				mul_req.a = {k_q[30:0], k_q[63:31]};
				mul_req.b = m3h_pkg::MUL_A;
				if (mul_rsp.done) begin
					if (full_q) begin
						state_d = m3h_pkg::ST_L2_X5;
					end else if (one_q || pend_q) begin
						state_d = m3h_pkg::ST_SA1;
					end else begin
						state_d = m3h_pkg::ST_FIN_XOR;
					end
				end
			end
			m3h_pkg::ST_L2_X5: begin
				state_d = m3h_pkg::ST_L2_ADD;
			end
			m3h_pkg::ST_L2_ADD: begin
				if (!last_q) begin
					state_d = m3h_pkg::ST_IDLE;
				end else if (pend_q) begin
					state_d = m3h_pkg::ST_SA1;
				end else begin
					state_d = m3h_pkg::ST_FIN_XOR;
				end
			end
			m3h_pkg::ST_FIN_XOR: begin
				state_d = m3h_pkg::ST_FIN_ADD1;
			end
			m3h_pkg::ST_FIN_ADD1: begin
				state_d = m3h_pkg::ST_FIN_ADD2;
			end
			m3h_pkg::ST_FIN_ADD2: begin
				state_d = m3h_pkg::ST_FM_A;
			end
			m3h_pkg::ST_FM_A: begin
				mul_req.a = fm_x ^ (fm_x >> 33);
				mul_req.b = m3h_pkg::FIN_A;
				if (mul_rsp.done) begin
					state_d = m3h_pkg::ST_FM_B;
				end
			end
			m3h_pkg::ST_FM_B: begin
				mul_req.a = k_q ^ (k_q >> 33);
				mul_req.b = m3h_pkg::FIN_B;
				if (mul_rsp.done) begin
					state_d = fm_q ? m3h_pkg::ST_SUM : m3h_pkg::ST_FM_A;
				end
			end
			m3h_pkg::ST_SUM: begin
				if (!out_valid_q || hash_out.ready) begin
					state_d = m3h_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = m3h_pkg::ST_IDLE;
			end
		endcase
	end

	// Control flags, seed register, byte total and output valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seed_q      <= '0;
			tot_q       <= '0;
			full_q      <= 1'b0;
			one_q       <= 1'b0;
			pend_q      <= 1'b0;
			last_q      <= 1'b0;
			in_msg_q    <= 1'b0;
			fm_q        <= 1'b0;
			go_q        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (seed_wr_en) begin
				seed_q <= seed_wr_data;
			end
			if (mul_req.start) begin
				go_q <= 1'b1;
			end else if (mul_rsp.done) begin
				go_q <= 1'b0;
			end
			if (accept) begin
				full_q   <= is_full;
				one_q    <= one_in;
				pend_q   <= part_in;
				last_q   <= msg_in.last;
				in_msg_q <= !msg_in.last;
				tot_q    <= (in_msg_q ? tot_q : 32'd0) + tot_inc;
			end
			// A tail scramble into lane one retires the low bytes first, then the
			// partial byte.
			if (state_q == m3h_pkg::ST_SA2 && mul_rsp.done && !full_q) begin
				if (one_q) begin
					one_q <= 1'b0;
				end else begin
					pend_q <= 1'b0;
				end
			end
			if (state_q == m3h_pkg::ST_L2_ADD) begin
				full_q <= 1'b0;
			end
			if (state_q == m3h_pkg::ST_FM_B && mul_rsp.done) begin
				fm_q <= !fm_q;
			end
			// A new hash takes the place of one that leaves in the same cycle.
			if (state_q == m3h_pkg::ST_SUM && state_d == m3h_pkg::ST_IDLE) begin
				out_valid_q <= 1'b1;
			end else if (hash_out.valid && hash_out.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Block capture, lane datapath and hash register.
	always_ff @(posedge clk) begin
		if (accept) begin
			lo_q   <= is_full ? msg_in.word_low : (msg_in.word_low & byte_mask(lo_n));
			hi_q   <= is_full ? msg_in.word_high : (msg_in.word_high & byte_mask(hi_n));
			part_q <= part_val;
			if (!in_msg_q) begin
				lane1_q <= seed_q;
				lane2_q <= seed_q;
			end
		end
		if (mul_rsp.done) begin
			k_q <= mul_rsp.product;
		end
		case (state_q)
			m3h_pkg::ST_SA2: begin
				if (mul_rsp.done) begin
					lane1_q <= full_q ? ({l1_mix[36:0], l1_mix[63:37]} + lane2_q) : l1_mix;
				end
			end
			m3h_pkg::ST_L1_X5: begin
				lane1_q <= {lane1_q[61:0], 2'b0} + lane1_q;
			end
			m3h_pkg::ST_L1_ADD: begin
				lane1_q <= lane1_q + m3h_pkg::ADD_ONE;
			end
			m3h_pkg::ST_SB2: begin
				if (mul_rsp.done) begin
					lane2_q <= full_q ? ({l2_mix[32:0], l2_mix[63:33]} + lane1_q) : l2_mix;
				end
			end
			m3h_pkg::ST_L2_X5: begin
				lane2_q <= {lane2_q[61:0], 2'b0} + lane2_q;
			end
			m3h_pkg::ST_L2_ADD: begin
				lane2_q <= lane2_q + m3h_pkg::ADD_TWO;
			end
			m3h_pkg::ST_FIN_XOR: begin
				lane1_q <= lane1_q ^ {32'b0, tot_q};
				lane2_q <= lane2_q ^ {32'b0, tot_q};
			end
			m3h_pkg::ST_FIN_ADD1: begin
				lane1_q <= lane1_q + lane2_q;
			end
			m3h_pkg::ST_FIN_ADD2: begin
				lane2_q <= lane2_q + lane1_q;
			end
			m3h_pkg::ST_FM_B: begin
				if (mul_rsp.done) begin
					if (fm_q) begin
						lane2_q <= fm_out;
					end else begin
						lane1_q <= fm_out;
					end
				end
			end
			m3h_pkg::ST_SUM: begin
				if (state_d == m3h_pkg::ST_IDLE) begin
					hash_q <= lane1_q + lane2_q;
				end
			end
			default: begin
				hash_q <= hash_q;
			end
		endcase
	end

	assign msg_in.ready        = (state_q == m3h_pkg::ST_IDLE);
	assign hash_out.valid      = out_valid_q;
	assign hash_out.hash_value = hash_q;

	// The multiplier is only started when it has finished the previous product.
	a_mul_start_free: assert property (@(posedge clk) disable iff (!arst_n)
		mul_req.start |-> !mul_rsp.busy)
		else $error("multiplier started while busy");

	// A product only comes back for a multiply the sequencer is waiting on.
	a_mul_done_expected: assert property (@(posedge clk) disable iff (!arst_n)
		mul_rsp.done |-> go_q)
		else $error("unexpected multiplier result");

	// A new block is never taken while a multiply is in flight.
	a_accept_no_mul: assert property (@(posedge clk) disable iff (!arst_n)
		accept |-> (!go_q && !mul_rsp.busy))
		else $error("block accepted during a multiply");

	// A hash is only presented after the final lane sum.
	a_out_from_sum: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == m3h_pkg::ST_SUM))
		else $error("hash presented outside the sum step");

endmodule

`default_nettype wire

// ----- sv/m3h_mul.sv -----
// ----------------------------------------------------------------------------
// m3h_mul: shared 64 x 64 multiplier, low 64 bits of the product.
// One 32 x 32 multiplier forms three partial products in turn and an
// accumulator folds them into the product.
// ----------------------------------------------------------------------------
`default_nettype none

module m3h_mul (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire m3h_pkg::m3h_mul_req_t req,
	output m3h_pkg::m3h_mul_rsp_t      rsp
);

	logic [m3h_pkg::WORD_W-1:0] a_q;
	logic [m3h_pkg::WORD_W-1:0] b_q;
	logic [m3h_pkg::WORD_W-1:0] acc_q;
	logic [m3h_pkg::WORD_W-1:0] prod_s1;
	logic [1:0]                 step_q;
	logic                       busy_q;
	logic                       done_q;
	logic [m3h_pkg::HALF_W-1:0] op_x;
	logic [m3h_pkg::HALF_W-1:0] op_y;

	// Operand halves for each partial product; the high by high term drops out.
	always_comb begin
		case (step_q)
			2'd0: begin
				op_x = a_q[31:0];
				op_y = b_q[31:0];
			end
			2'd1: begin
				op_x = a_q[31:0];
				op_y = b_q[63:32];
			end
			2'd2: begin
				op_x = a_q[63:32];
				op_y = b_q[31:0];
			end
			default: begin
				op_x = '0;
				op_y = '0;
			end
		endcase
	end

	// Step control; done is raised for one cycle after the last partial product.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= 2'd0;
		end else begin
			done_q <= busy_q && !req.start && (step_q == 2'd3);
			if (req.start) begin
				busy_q <= 1'b1;
				step_q <= 2'd0;
			end else if (busy_q) begin
				step_q <= step_q + 2'd1;
				if (step_q == 2'd3) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	// Operand capture, registered partial product and accumulation.
	always_ff @(posedge clk) begin
		if (req.start) begin
			a_q <= req.a;
			b_q <= req.b;
		end
		if (busy_q) begin
			prod_s1 <= 64'(op_x) * 64'(op_y);
			case (step_q)
				2'd1:    acc_q <= prod_s1;
				2'd2:    acc_q <= acc_q + {prod_s1[31:0], 32'b0};
				2'd3:    acc_q <= acc_q + {prod_s1[31:0], 32'b0};
				default: acc_q <= acc_q;
			endcase
		end
	end

	assign rsp.busy    = busy_q;
	assign rsp.done    = done_q;
	assign rsp.product = acc_q;

endmodule

`default_nettype wire

// ----- tb/murmur3_x64_bit_length_hash_unit_test.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// murmur3_x64_bit_length_hash_unit_test: self-checking bench for the hash unit
// A table of directed blocks runs first, then short random messages go through
// several seed settings and idle patterns. A behavioral model of the two hash
// lanes predicts unpinned hashes; each hash transaction is checked in order.
// ----------------------------------------------------------------------------
module murmur3_x64_bit_length_hash_unit_test;

	// One message block, with an optional hash that is known by hand.
	typedef struct packed {
		logic [63:0] word_low;
		logic [63:0] word_high;
		logic [4:0]  valid_bytes;
		logic [7:0]  partial_byte;
		logic [2:0]  partial_bits;
		logic        last;
		logic        pinned;
		logic [63:0] pinned_hash;
	} block_row_t;

	localparam int DIRECTED_ROWS = 17;
	localparam int SETTLE_CYCLES = 100;
	localparam int HOLD_CYCLES   = 300;
	localparam int REPORT_LIMIT  = 10;
	localparam logic [63:0] ALL_ONES = 64'hffff_ffff_ffff_ffff;

	// Directed blocks: tail lengths at every boundary, saturation, partial bits.
	block_row_t directed_rows [DIRECTED_ROWS] = '{
		// Empty message right after reset: zero lanes and zero length hash to zero.
		'{64'h0, 64'h0, 5'd0, 8'h00, 3'd0, 1'b1, 1'b1, 64'h0},
		'{ALL_ONES, ALL_ONES, 5'd16, 8'hff, 3'd7, 1'b1, 1'b0, 64'h0},
		'{ALL_ONES, ALL_ONES, 5'd1, 8'h00, 3'd0, 1'b1, 1'b0, 64'h0},
		'{64'h0123456789abcdef, 64'hfedcba9876543210, 5'd8, 8'h00, 3'd0, 1'b1, 1'b0, 64'h0},
		'{64'h0123456789abcdef, 64'hfedcba9876543210, 5'd9, 8'h00, 3'd0, 1'b1, 1'b0, 64'h0},
		'{ALL_ONES, ALL_ONES, 5'd15, 8'h00, 3'd0, 1'b1, 1'b0, 64'h0},
		'{64'h8000000000000001, 64'h8000000000000001, 5'd17, 8'ha5, 3'd4, 1'b1, 1'b0, 64'h0},
		'{ALL_ONES, ALL_ONES, 5'd31, 8'hff, 3'd7, 1'b1, 1'b0, 64'h0},
		'{64'h0, 64'h0, 5'd0, 8'h80, 3'd1, 1'b1, 1'b0, 64'h0},
		'{64'h0, 64'h0, 5'd0, 8'hfe, 3'd7, 1'b1, 1'b0, 64'h0},
		'{64'h5555aaaa5555aaaa, 64'haaaa5555aaaa5555, 5'd3, 8'hff, 3'd5, 1'b0, 1'b0, 64'h0},
		'{64'h0f0f0f0f0f0f0f0f, 64'hf0f0f0f0f0f0f0f0, 5'd16, 8'h00, 3'd0, 1'b1, 1'b0, 64'h0},
		'{64'h0, 64'h0, 5'd31, 8'hff, 3'd7, 1'b0, 1'b0, 64'h0},
		'{ALL_ONES, ALL_ONES, 5'd0, 8'h00, 3'd0, 1'b0, 1'b0, 64'h0},
		'{64'h1122334455667788, 64'h99aabbccddeeff00, 5'd5, 8'h60, 3'd3, 1'b1, 1'b0, 64'h0},
		'{64'h0, 64'h0, 5'd7, 8'hff, 3'd0, 1'b1, 1'b0, 64'h0},
		'{64'h0, ALL_ONES, 5'd12, 8'h40, 3'd2, 1'b1, 1'b0, 64'h0}
	};

	logic        clk;
	logic        arst_n;
	logic        seed_wr_en;
	logic [63:0] seed_wr_data;
	logic        pin_now;
	logic [63:0] pin_hash_now;

	m3h_msg_if  msg_ch ();
	m3h_hash_if hash_ch ();

	murmur3_x64_bit_length_hash_unit DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.seed_wr_en   (seed_wr_en),
		.seed_wr_data (seed_wr_data),
		.msg_in       (msg_ch),
		.hash_out     (hash_ch)
	);

	// Idle controls for the sender and the receiver, and the fault count.
	int unsigned send_idle_pct = 0;
	int unsigned stall_pct     = 0;
	int unsigned hold_left     = 0;
	int unsigned fault_count   = 0;

	// Model state: the two lanes, the byte count and the seed copy.
	logic [63:0] lane_a;
	logic [63:0] lane_b;
	logic [31:0] bytes_seen;
	logic [63:0] seed_copy;
	bit          msg_open;
	logic [63:0] hash_expect_q [$];

	// Clock generation.
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Hard limit on the run time.
	initial begin
		#5_000_000;
		$display("Simulation FAILED");
		$finish;
	end

	function automatic logic [63:0] rotl64(input logic [63:0] v, input int unsigned s);
		return (v << s) | (v >> (64 - s));
	endfunction

	function automatic logic [63:0] scramble_lo(input logic [63:0] k);
		logic [63:0] t;
		t = k * m3h_pkg::MUL_A;
		t = rotl64(t, 31);
		return t * m3h_pkg::MUL_B;
	endfunction

	function automatic logic [63:0] scramble_hi(input logic [63:0] k);
		logic [63:0] t;
		t = k * m3h_pkg::MUL_B;
		t = rotl64(t, 33);
		return t * m3h_pkg::MUL_A;
	endfunction

	function automatic logic [63:0] avalanche(input logic [63:0] k);
		logic [63:0] t;
		t = k ^ (k >> 33);
		t = t * m3h_pkg::FIN_A;
		t = t ^ (t >> 33);
		t = t * m3h_pkg::FIN_B;
		return t ^ (t >> 33);
	endfunction

	// Keeps the low n bytes of a word and clears the rest.
	function automatic logic [63:0] keep_bytes(input logic [63:0] w, input int unsigned n);
		if (n >= 8) begin
			return w;
		end
		return w & ((64'd1 << (8 * n)) - 64'd1);
	endfunction

	// Full block mix of both lanes, with the lane rotate and add.
	function automatic void mix_full_block(input logic [63:0] lo, input logic [63:0] hi);
		lane_a = lane_a ^ scramble_lo(lo);
		lane_a = rotl64(lane_a, 27);
		lane_a = lane_a + lane_b;
		lane_a = lane_a * 64'd5 + m3h_pkg::ADD_ONE;
		lane_b = lane_b ^ scramble_hi(hi);
		lane_b = rotl64(lane_b, 31);
		lane_b = lane_b + lane_a;
		lane_b = lane_b * 64'd5 + m3h_pkg::ADD_TWO;
	endfunction

	// Absorbs one block into the lanes; returns 1 with the hash on the last block.
	function automatic bit absorb_into_lanes(input block_row_t blk, output logic [63:0] digest);
		int unsigned nbytes;
		digest = '0;
		if (!msg_open) begin
			lane_a     = seed_copy;
			lane_b     = seed_copy;
			bytes_seen = '0;
			msg_open   = 1'b1;
		end
		if (!blk.last) begin
			mix_full_block(blk.word_low, blk.word_high);
			bytes_seen = bytes_seen + 32'd16;
			return 1'b0;
		end
		nbytes = (blk.valid_bytes > 5'd16) ? 16 : int'(blk.valid_bytes);
		if (nbytes == 16) begin
			mix_full_block(blk.word_low, blk.word_high);
		end else begin
			if (nbytes > 8) begin
				lane_b = lane_b ^ scramble_hi(keep_bytes(blk.word_high, nbytes - 8));
			end
			if (nbytes > 0) begin
				lane_a = lane_a ^ scramble_lo(keep_bytes(blk.word_low, nbytes));
			end
		end
		bytes_seen = bytes_seen + 32'(nbytes);
		if (blk.partial_bits != 3'd0) begin
			lane_a = lane_a ^ scramble_lo(64'(blk.partial_byte >> (8 - int'(blk.partial_bits))));
		end
		// Finalization with the byte count and both avalanche passes.
		lane_a = lane_a ^ {32'd0, bytes_seen};
		lane_b = lane_b ^ {32'd0, bytes_seen};
		lane_a = lane_a + lane_b;
		lane_b = lane_b + lane_a;
		lane_a = avalanche(lane_a);
		lane_b = avalanche(lane_b);
		digest = lane_a + lane_b;
		msg_open = 1'b0;
		return 1'b1;
	endfunction

	task automatic log_fault(input string what);
		fault_count++;
		if (fault_count <= REPORT_LIMIT) begin
			$display("%0t ns: %s", $time, what);
		end
	endtask

	// Scoreboard: predicts on every accepted block, checks every accepted hash.
	always @(posedge clk) begin : scoreboard
		block_row_t  taken;
		logic [63:0] digest;
		logic [63:0] want;
		if (arst_n) begin
			if (seed_wr_en) begin
				seed_copy = seed_wr_data;
			end
			if (msg_ch.valid && msg_ch.ready) begin
				taken.word_low     = msg_ch.word_low;
				taken.word_high    = msg_ch.word_high;
				taken.valid_bytes  = msg_ch.valid_bytes;
				taken.partial_byte = msg_ch.partial_byte;
				taken.partial_bits = msg_ch.partial_bits;
				taken.last         = msg_ch.last;
				taken.pinned       = 1'b0;
				taken.pinned_hash  = '0;
				if (absorb_into_lanes(taken, digest)) begin
					hash_expect_q.push_back(pin_now ? pin_hash_now : digest);
				end
			end
			if (hash_ch.valid && hash_ch.ready) begin
				if (hash_expect_q.size() == 0) begin
					log_fault($sformatf("unexpected hash %h", hash_ch.hash_value));
				end else begin
					want = hash_expect_q.pop_front();
					if (want !== hash_ch.hash_value) begin
						log_fault($sformatf("hash_value expected %h, got %h",
							want, hash_ch.hash_value));
					end
				end
			end
		end
	end

	// Receiver: random stalls, or a long hold-off counted down here.
	initial begin
		hash_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_left > 0) begin
				hash_ch.ready = 1'b0;
				hold_left--;
			end else begin
				hash_ch.ready = ($urandom_range(99) >= stall_pct);
			end
		end
	end

	function automatic logic [63:0] random_word();
		case ($urandom_range(0, 9))
			0: return '0;
			1: return ALL_ONES;
			default: return {$urandom, $urandom};
		endcase
	endfunction

	function automatic block_row_t random_row(input logic last_flag);
		block_row_t row;
		row.word_low     = random_word();
		row.word_high    = random_word();
		row.valid_bytes  = ($urandom_range(0, 9) < 8) ? 5'($urandom_range(0, 16))
		                                              : 5'($urandom_range(17, 31));
		row.partial_byte = 8'($urandom);
		row.partial_bits = 3'($urandom);
		row.last         = last_flag;
		row.pinned       = 1'b0;
		row.pinned_hash  = '0;
		return row;
	endfunction

	// Offers one block from a falling edge and returns at the falling edge after
	// the transaction, with valid still high.
	task automatic offer_block(input block_row_t row);
		while ($urandom_range(99) < send_idle_pct) begin
			msg_ch.valid = 1'b0;
			@(negedge clk);
		end
		msg_ch.word_low     = row.word_low;
		msg_ch.word_high    = row.word_high;
		msg_ch.valid_bytes  = row.valid_bytes;
		msg_ch.partial_byte = row.partial_byte;
		msg_ch.partial_bits = row.partial_bits;
		msg_ch.last         = row.last;
		pin_now             = row.pinned;
		pin_hash_now        = row.pinned_hash;
		msg_ch.valid        = 1'b1;
		do @(posedge clk); while (!msg_ch.ready);
		@(negedge clk);
	endtask

	// Stops sending until every hash is back and the unit has gone quiet.
	task automatic drain_results();
		msg_ch.valid = 1'b0;
		while (hash_expect_q.size() != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic load_seed(input logic [63:0] value);
		seed_wr_data = value;
		seed_wr_en   = 1'b1;
		@(negedge clk);
		seed_wr_en   = 1'b0;
	endtask

	// Random messages of one to four blocks, always closed by a last block.
	task automatic run_random(input int unsigned item_goal, input bit pause_midway);
		int unsigned sent;
		int unsigned body;
		bit          paused;
		sent   = 0;
		paused = 1'b0;
		while (sent < item_goal) begin
			body = $urandom_range(0, 3);
			repeat (body) begin
				offer_block(random_row(1'b0));
				sent++;
			end
			offer_block(random_row(1'b1));
			sent++;
			if (pause_midway && !paused && sent >= item_goal / 2) begin
				drain_results();
				paused = 1'b1;
			end
		end
		drain_results();
	endtask

	// Main sequence.
	initial begin : stimulus
		arst_n              = 1'b0;
		seed_wr_en          = 1'b0;
		seed_wr_data        = '0;
		pin_now             = 1'b0;
		pin_hash_now        = '0;
		msg_ch.valid        = 1'b0;
		msg_ch.word_low     = '0;
		msg_ch.word_high    = '0;
		msg_ch.valid_bytes  = '0;
		msg_ch.partial_byte = '0;
		msg_ch.partial_bits = '0;
		msg_ch.last         = 1'b0;
		seed_copy           = '0;
		lane_a              = '0;
		lane_b              = '0;
		bytes_seen          = '0;
		msg_open            = 1'b0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed table at the reset seed, no idling.
		foreach (directed_rows[i]) begin
			offer_block(directed_rows[i]);
		end
		drain_results();

		// Random phases, each under its own seed and idle pattern.
		load_seed(ALL_ONES);
		run_random(200, 1'b0);

		send_idle_pct = 72;
		load_seed({$urandom, $urandom});
		run_random(200, 1'b1);

		send_idle_pct = 0;
		stall_pct     = 72;
		load_seed(64'h0);
		run_random(200, 1'b0);

		send_idle_pct = 10;
		stall_pct     = 10;
		load_seed({$urandom, $urandom});
		run_random(180, 1'b0);

		// Back pressure: the receiver holds off while single-block messages pile up.
		send_idle_pct = 0;
		stall_pct     = 0;
		load_seed(64'h1);
		@(posedge clk);
		hold_left = HOLD_CYCLES;
		@(negedge clk);
		repeat (12) offer_block(random_row(1'b1));
		drain_results();

		if (hash_expect_q.size() != 0) begin
			log_fault($sformatf("%0d hashes never arrived", hash_expect_q.size()));
		end
		if (fault_count == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule
